>>> rtl/cfir_pkg.sv
// Shared types and constants for the complex FIR filter.
`default_nettype none

package cfir_pkg;

    localparam int TAPS   = 128;
    localparam int TAPS_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SMP_W  = 16;
    localparam int CPLX_W = 2 * SMP_W;
    localparam int PROD_W = 2 * SMP_W;
    localparam int ACC_W  = 40;
    localparam int CIDX_W = 7;

    typedef enum logic [0:0] {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } op_t;

    typedef logic signed [SMP_W-1:0] smp_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Sequencer to MAC control
    typedef struct packed {
        logic start;
        logic vld;
        logic last;
    } mac_ctl_t;

endpackage

`default_nettype wire

>>> rtl/cfir_if.sv
// Request and result channel interfaces of the complex FIR filter.
`default_nettype none

interface cfir_in_if
    import cfir_pkg::*;
;
    logic              valid;
    logic              ready;
    op_t               operation;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [6:0]        coef_index;
    logic signed [15:0] coef_re;
    logic signed [15:0] coef_im;

    modport source (
        output valid, operation, sample_re, sample_im, coef_index, coef_re, coef_im,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_re, sample_im, coef_index, coef_re, coef_im,
        output ready
    );
endinterface

interface cfir_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] out_re;
    logic signed [39:0] out_im;

    modport source (
        output valid, out_re, out_im,
        input  ready
    );
    modport sink (
        input  valid, out_re, out_im,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/cfir_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/cfir_mac.sv
// Complex multiply-accumulate unit: registered products, then 40-bit accumulate.
`default_nettype none

module cfir_mac
    import cfir_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mac_ctl_t ctl,
    input  wire smp_t     smp_re,
    input  wire smp_t     smp_im,
    input  wire smp_t     cf_re,
    input  wire smp_t     cf_im,
    output acc_t          acc_re,
    output acc_t          acc_im,
    output logic          done
);

    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_W-1:0] p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic                     pvld_reg, plast_reg, done_reg;
    acc_t                     acc_re_reg, acc_im_reg;
    acc_t                     acc_re_next, acc_im_next;
    acc_t                     e_rr, e_ii, e_ri, e_ir;

    always_comb
    begin
        p_rr_next = smp_re * cf_re;
        p_ii_next = smp_im * cf_im;
        p_ri_next = smp_re * cf_im;
        p_ir_next = smp_im * cf_re;
    end

    assign e_rr = {{(ACC_W-PROD_W){p_rr_reg[PROD_W-1]}}, p_rr_reg};
    assign e_ii = {{(ACC_W-PROD_W){p_ii_reg[PROD_W-1]}}, p_ii_reg};
    assign e_ri = {{(ACC_W-PROD_W){p_ri_reg[PROD_W-1]}}, p_ri_reg};
    assign e_ir = {{(ACC_W-PROD_W){p_ir_reg[PROD_W-1]}}, p_ir_reg};

    // Sum wraps modulo 2^40
    assign acc_re_next = acc_re_reg + e_rr - e_ii;
    assign acc_im_next = acc_im_reg + e_ri + e_ir;

    always_ff @(posedge clk)
    begin
        p_rr_reg <= p_rr_next;
        p_ii_reg <= p_ii_next;
        p_ri_reg <= p_ri_next;
        p_ir_reg <= p_ir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg   <= 1'b0;
            plast_reg  <= 1'b0;
            done_reg   <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            pvld_reg  <= ctl.vld;
            plast_reg <= ctl.last;
            done_reg  <= pvld_reg && plast_reg;
            if (ctl.start)
            begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end
            else if (pvld_reg)
            begin
                acc_re_reg <= acc_re_next;
                acc_im_reg <= acc_im_next;
            end
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> rtl/complex_fir_filter.sv
// Complex FIR filter top level: tap sequencer, delay-line and coefficient RAMs.
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    operation, sample_re/im, coef_index, coef_re/im
//  result   out  valid/ready    out_re, out_im (40-bit Q.30)
//
// Coefficient request: taken in IDLE, no result.
// Sample request: one tap per cycle through the single read port of each
//   RAM and the shared complex MAC.
// Reset clears pointer and per-entry valid bits; an unwritten entry reads as zero.
// A finished result waits in the output register; the next request is taken
//   meanwhile, and its result stalls in DONE until the register frees.
`default_nettype none

module complex_fir_filter
    import cfir_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfir_in_if.sink    item,
    cfir_out_if.source result
);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        DRAIN,
        DONE
    } state_t;

    state_t              state_reg;
    logic [TAPS_W-1:0]   wp_reg;
    logic [TAPS_W-1:0]   rd_ptr_reg;
    logic [TAPS_W-1:0]   k_reg;
    logic [TAPS-1:0]     dl_valid_reg;
    logic [TAPS-1:0]     cf_valid_reg;
    logic                rd_vld_reg, rd_last_reg;
    logic                dl_hit_reg, cf_hit_reg;
    logic                start_reg;
    logic                out_valid_reg;
    acc_t                out_re_reg, out_im_reg;

    logic                accept;
    logic                smp_wr, cf_wr;
    logic [TAPS_W-1:0]   cf_wr_addr;
    logic [TAPS_W-1:0]   wp_next, rd_ptr_next;
    logic                k_last;
    logic                out_free;
    logic [CPLX_W-1:0]   dl_rd_data, cf_rd_data;
    mac_ctl_t            mac_ctl;
    smp_t                smp_re, smp_im, cf_re, cf_im;
    acc_t                acc_re, acc_im;
    logic                mac_done;

    assign item.ready = (state_reg == IDLE);
    assign accept     = item.valid && item.ready;
    assign smp_wr     = accept && (item.operation == OP_FILTER);
    assign cf_wr      = accept && (item.operation == OP_COEF)
                        && (int'(item.coef_index) < TAPS);
    assign cf_wr_addr = TAPS_W'(item.coef_index);

    assign wp_next     = (wp_reg == TAPS_W'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == '0) ? TAPS_W'(TAPS - 1) : rd_ptr_reg - 1'b1;
    assign k_last      = (k_reg == TAPS_W'(TAPS - 1));
    assign out_free    = !out_valid_reg || result.ready;

    cfir_ram #(
        .WIDTH (CPLX_W),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (smp_wr),
        .wr_addr (wp_reg),
        .wr_data ({item.sample_re, item.sample_im}),
        .rd_addr (rd_ptr_reg),
        .rd_data (dl_rd_data)
    );

    cfir_ram #(
        .WIDTH (CPLX_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (cf_wr),
        .wr_addr (cf_wr_addr),
        .wr_data ({item.coef_re, item.coef_im}),
        .rd_addr (k_reg),
        .rd_data (cf_rd_data)
    );

    // Never-written entries read as zero
    assign smp_re = dl_hit_reg ? smp_t'(dl_rd_data[CPLX_W-1:SMP_W]) : '0;
    assign smp_im = dl_hit_reg ? smp_t'(dl_rd_data[SMP_W-1:0])      : '0;
    assign cf_re  = cf_hit_reg ? smp_t'(cf_rd_data[CPLX_W-1:SMP_W]) : '0;
    assign cf_im  = cf_hit_reg ? smp_t'(cf_rd_data[SMP_W-1:0])      : '0;

    assign mac_ctl.start = start_reg;
    assign mac_ctl.vld   = rd_vld_reg;
    assign mac_ctl.last  = rd_last_reg;

    cfir_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .smp_re (smp_re),
        .smp_im (smp_im),
        .cf_re  (cf_re),
        .cf_im  (cf_im),
        .acc_re (acc_re),
        .acc_im (acc_im),
        .done   (mac_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            wp_reg        <= '0;
            rd_ptr_reg    <= '0;
            k_reg         <= '0;
            dl_valid_reg  <= '0;
            cf_valid_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            dl_hit_reg    <= 1'b0;
            cf_hit_reg    <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_re_reg    <= '0;
            out_im_reg    <= '0;
        end
        else
        begin
            start_reg   <= smp_wr;
            rd_vld_reg  <= (state_reg == RUN);
            rd_last_reg <= (state_reg == RUN) && k_last;
            dl_hit_reg  <= dl_valid_reg[rd_ptr_reg];
            cf_hit_reg  <= cf_valid_reg[k_reg];

            if (cf_wr)
            begin
                cf_valid_reg[cf_wr_addr] <= 1'b1;
            end

            // In DONE the output register is reloaded instead
            if (out_valid_reg && result.ready && (state_reg != DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (smp_wr)
                    begin
                        dl_valid_reg[wp_reg] <= 1'b1;
                        rd_ptr_reg           <= wp_reg;
                        wp_reg               <= wp_next;
                        k_reg                <= '0;
                        state_reg            <= RUN;
                    end
                end
                RUN:
                begin
                    rd_ptr_reg <= rd_ptr_next;
                    if (k_last)
                    begin
                        state_reg <= DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                DRAIN:
                begin
                    if (mac_done)
                    begin
                        state_reg <= DONE;
                    end
                end
                DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_re_reg    <= acc_re;
                        out_im_reg    <= acc_im;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.out_re = out_re_reg;
    assign result.out_im = out_im_reg;

endmodule

`default_nettype wire
